/* design/bku_pkg.sv */
// Package with the command states and status codes of the bytekiller unpacker.
package bku_pkg;

  typedef enum logic [3:0] {
    CS_OP1     = 4'd0,
    CS_OP2     = 4'd1,
    CS_OP3     = 4'd2,
    CS_LITLEN3 = 4'd3,
    CS_LITLEN8 = 4'd4,
    CS_CPYLEN  = 4'd5,
    CS_OFF     = 4'd6,
    CS_LITBYTE = 4'd7,
    CS_COPY    = 4'd8,
    CS_DONE    = 4'd15
  } cmd_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_READ,
    ST_EMIT,
    ST_OUT
  } seq_state_e;

  localparam logic [2:0] STAT_ACCEPTED = 3'd0;
  localparam logic [2:0] STAT_BYTE     = 3'd1;
  localparam logic [2:0] STAT_NEEDWORD = 3'd2;
  localparam logic [2:0] STAT_REFUSED  = 3'd3;
  localparam logic [2:0] STAT_FINISHED = 3'd4;

  localparam logic [31:0] SENTINEL_BIT = 32'h8000_0000;

endpackage

/* design/bku_ram.sv */
// Generic RAM with one write port and one registered read port.
module bku_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/bytekiller_unpacker.sv */
// Top level of the bytekiller unpacker: header, bit fetch, command sequencer, history.
//
// A word beat (opcode 0) is answered in the cycle right after it is accepted. A byte
// request walks the command and data bits one at a time, since the bit fetch unit
// shifts out one bit per cycle while bits are left in the bit register or the word
// buffer. Each finished field then passes a step in which the fetch finds it complete
// and a step for the decision. A copied byte reads the history RAM in READ, and every
// byte is written back to history in EMIT. The block accepts no beat while a result
// is pending or being computed. History is 4096 bytes in one RAM and has no clearing
// pass.
module bytekiller_unpacker #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] packed_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic        check_ok_o,
  output logic        overrun_o
);

  localparam int HW = $clog2(HISTORY_DEPTH);

  bku_pkg::seq_state_e seq_q, seq_d;
  bku_pkg::cmd_state_e cmd_q, cmd_d;
  logic [1:0]  hdr_q, hdr_d;
  logic [31:0] bits_q, bits_d, chk_q, chk_d, rem_q, rem_d, wbuf_q, wbuf_d;
  logic        wfull_q, wfull_d;
  logic [15:0] acc_q, acc_d;
  logic [3:0]  left_q, left_d;
  logic [8:0]  run_q, run_d;
  logic [11:0] off_q, off_d;
  logic [HW-1:0] hptr_q, hptr_d;
  logic [2:0]  stat_q, stat_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d, ok_q, ok_d, over_q, over_d;

  logic        ram_we;
  logic [HW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;

  bku_ram #(.Width(8), .Depth(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (hptr_q),
    .wdata_i (byte_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = hptr_q - HW'(off_q);
  assign ram_we    = (seq_q == bku_pkg::ST_EMIT);

  assign in_ready_o  = (seq_q == bku_pkg::ST_IDLE);
  assign out_valid_o = (seq_q == bku_pkg::ST_OUT);
  assign status_o    = stat_q;
  assign data_byte_o = byte_q;
  assign last_o      = last_q;
  assign check_ok_o  = ok_q;
  assign overrun_o   = over_q;

  // Sequencer: at most one bit or one decision per cycle, holding in OUT until the result is taken.
  always_comb begin
    seq_d = seq_q; cmd_d = cmd_q; hdr_d = hdr_q; bits_d = bits_q; chk_d = chk_q;
    rem_d = rem_q; wbuf_d = wbuf_q; wfull_d = wfull_q; acc_d = acc_q;
    left_d = left_q; run_d = run_q; off_d = off_q; hptr_d = hptr_q;
    stat_d = stat_q; byte_d = byte_q; last_d = last_q; ok_d = ok_q; over_d = over_q;
    case (seq_q)
      bku_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = '0; last_d = 1'b0; ok_d = 1'b0; over_d = 1'b0;
          seq_d = bku_pkg::ST_OUT;
          if (!opcode_i) begin
            stat_d = bku_pkg::STAT_ACCEPTED;
            case (hdr_q)
              2'd0: begin rem_d = packed_word_i; hdr_d = 2'd1; end
              2'd1: begin chk_d = packed_word_i; hdr_d = 2'd2; end
              2'd2: begin
                bits_d = packed_word_i; chk_d = chk_q ^ packed_word_i; hdr_d = 2'd3;
                cmd_d = (rem_q == '0) ? bku_pkg::CS_DONE : bku_pkg::CS_OP1;
                acc_d = '0; left_d = 4'd1;
              end
              default: begin
                if (cmd_q == bku_pkg::CS_DONE || wfull_q) begin
                  stat_d = bku_pkg::STAT_REFUSED;
                end else begin
                  wbuf_d = packed_word_i; wfull_d = 1'b1;
                end
              end
            endcase
          end else if (hdr_q != 2'd3) begin
            stat_d = bku_pkg::STAT_NEEDWORD;
          end else if (cmd_q == bku_pkg::CS_DONE) begin
            stat_d = bku_pkg::STAT_FINISHED;
          end else begin
            stat_d = bku_pkg::STAT_NEEDWORD;
            seq_d = bku_pkg::ST_FETCH;
          end
        end
      end
      bku_pkg::ST_FETCH: begin
        if (left_q == '0) begin
          seq_d = bku_pkg::ST_DECODE;
        end else if (bits_q[31:1] == '0) begin
          if (!wfull_q) begin
            seq_d = bku_pkg::ST_OUT;
          end else begin
            wfull_d = 1'b0; chk_d = chk_q ^ wbuf_q;
            acc_d = {acc_q[14:0], wbuf_q[0]};
            bits_d = (wbuf_q >> 1) | bku_pkg::SENTINEL_BIT;
            left_d = left_q - 4'd1;
          end
        end else begin
          acc_d = {acc_q[14:0], bits_q[0]};
          bits_d = bits_q >> 1;
          left_d = left_q - 4'd1;
        end
      end
      bku_pkg::ST_DECODE: begin
        seq_d = bku_pkg::ST_FETCH; acc_d = '0;
        case (cmd_q)
          bku_pkg::CS_OP1: begin
            cmd_d = (acc_q == '0) ? bku_pkg::CS_OP2 : bku_pkg::CS_OP3;
            left_d = (acc_q == '0) ? 4'd1 : 4'd2;
          end
          bku_pkg::CS_OP2: begin
            if (acc_q == '0) begin
              cmd_d = bku_pkg::CS_LITLEN3; left_d = 4'd3;
            end else begin
              run_d = 9'd2; cmd_d = bku_pkg::CS_OFF; left_d = 4'd8;
            end
          end
          bku_pkg::CS_OP3: begin
            case (acc_q[1:0])
              2'd0: begin run_d = 9'd3; cmd_d = bku_pkg::CS_OFF; left_d = 4'd9; end
              2'd1: begin run_d = 9'd4; cmd_d = bku_pkg::CS_OFF; left_d = 4'd10; end
              2'd2: begin cmd_d = bku_pkg::CS_CPYLEN; left_d = 4'd8; end
              default: begin cmd_d = bku_pkg::CS_LITLEN8; left_d = 4'd8; end
            endcase
          end
          bku_pkg::CS_LITLEN3: begin
            run_d = {6'd0, acc_q[2:0]} + 9'd1; cmd_d = bku_pkg::CS_LITBYTE; left_d = 4'd8;
          end
          bku_pkg::CS_LITLEN8: begin
            run_d = {1'b0, acc_q[7:0]} + 9'd9; cmd_d = bku_pkg::CS_LITBYTE; left_d = 4'd8;
          end
          bku_pkg::CS_CPYLEN: begin
            run_d = {1'b0, acc_q[7:0]} + 9'd1; cmd_d = bku_pkg::CS_OFF; left_d = 4'd12;
          end
          bku_pkg::CS_OFF: begin
            off_d = acc_q[11:0]; cmd_d = bku_pkg::CS_COPY; left_d = 4'd0;
            seq_d = bku_pkg::ST_READ;
          end
          bku_pkg::CS_LITBYTE: begin
            byte_d = acc_q[7:0]; acc_d = acc_q; seq_d = bku_pkg::ST_EMIT;
          end
          bku_pkg::CS_COPY: begin
            acc_d = acc_q; seq_d = bku_pkg::ST_READ;
          end
          default: begin
            cmd_d = bku_pkg::CS_OP1; left_d = 4'd1;
          end
        endcase
      end
      bku_pkg::ST_READ: begin
        // RAM address settles from off_q; data is registered here.
        seq_d = (cmd_q == bku_pkg::CS_COPY && left_q == 4'd15) ? bku_pkg::ST_EMIT
                                                               : bku_pkg::ST_READ;
        left_d = 4'd15;
        if (left_q == 4'd15) left_d = 4'd0;
      end
      bku_pkg::ST_EMIT: begin
        if (cmd_q == bku_pkg::CS_COPY) byte_d = ram_rdata;
        seq_d = bku_pkg::ST_OUT;
      end
      default: begin
        if (out_ready_i) seq_d = bku_pkg::ST_IDLE;
      end
    endcase

    // Bookkeeping of an emitted byte, done in the cycle of the RAM write.
    if (seq_q == bku_pkg::ST_EMIT) begin
      hptr_d = hptr_q + 1'b1;
      run_d = run_q - 9'd1;
      rem_d = rem_q - 32'd1;
      stat_d = bku_pkg::STAT_BYTE;
      acc_d = '0;
      if (rem_q == 32'd1) begin
        last_d = 1'b1; ok_d = (chk_q == '0); over_d = (run_q != 9'd1);
        cmd_d = bku_pkg::CS_DONE; left_d = 4'd0;
      end else if (run_q == 9'd1) begin
        cmd_d = bku_pkg::CS_OP1; left_d = 4'd1;
      end else if (cmd_q == bku_pkg::CS_LITBYTE) begin
        left_d = 4'd8;
      end else begin
        left_d = 4'd0;
      end
    end
  end

  // The byte written to history is byte_q, which is held in EMIT; a copied byte loaded there would come too late.
  // A copy therefore loads byte_q in READ's final cycle instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= bku_pkg::ST_IDLE; cmd_q <= bku_pkg::CS_OP1; hdr_q <= '0;
      bits_q <= '0; chk_q <= '0; rem_q <= '0; wbuf_q <= '0; wfull_q <= 1'b0;
      acc_q <= '0; left_q <= '0; run_q <= '0; off_q <= '0; hptr_q <= '0;
      stat_q <= '0; byte_q <= '0; last_q <= 1'b0; ok_q <= 1'b0; over_q <= 1'b0;
    end else begin
      seq_q <= seq_d; cmd_q <= cmd_d; hdr_q <= hdr_d; bits_q <= bits_d;
      chk_q <= chk_d; rem_q <= rem_d; wbuf_q <= wbuf_d; wfull_q <= wfull_d;
      acc_q <= acc_d; left_q <= left_d; run_q <= run_d; off_q <= off_d;
      hptr_q <= hptr_d; stat_q <= stat_d; last_q <= last_d; ok_q <= ok_d;
      over_q <= over_d;
      if (seq_q == bku_pkg::ST_READ && left_q == 4'd15) byte_q <= ram_rdata;
      else if (seq_q != bku_pkg::ST_EMIT) byte_q <= byte_d;
    end
  end

  // A result beat holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");
  // Input and output are never open together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("ready while result pending");
  // Last byte only comes with a byte status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> status_o == bku_pkg::STAT_BYTE)
    else $error("last without byte");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the bytekiller unpacker, with a stream encoder and a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int HIST_DEPTH  = 4096;
  localparam int STALL_LIMIT = 6000;
  localparam int BYTE_TARGET = 680;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic       last;
    logic       ok;
    logic       over;
  } unpack_res_t;

  typedef struct packed {
    logic        op;
    logic [31:0] word;
    unpack_res_t res;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [31:0] packed_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  data_byte_o;
  logic        last_o;
  logic        check_ok_o;
  logic        overrun_o;

  bytekiller_unpacker dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state, a copy of the unpacker's own.
  logic [1:0]  hdr_phase;
  logic [31:0] bit_reg, check_acc, bytes_left, word_buf;
  logic        word_buf_full;
  bku_pkg::cmd_state_e cmd_st;
  logic [15:0] code_acc;
  int          code_left;
  logic [8:0]  run_len;
  logic [11:0] copy_off;
  logic [7:0]  hist_mem [HIST_DEPTH];
  logic [11:0] hist_ptr;

  beat_t       pending_beats[$];
  unpack_res_t expected_results[$];
  bit          stream_bits[$];
  logic [31:0] refill_words[$];
  int          bytes_encoded;
  int          errors = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          bytes_seen = 0;
  bit          sender_paused = 1'b0;
  bit          pause_done = 1'b0;

  function automatic void goto_state(bku_pkg::cmd_state_e st, int nbits);
    cmd_st    = st;
    code_acc  = '0;
    code_left = nbits;
  endfunction

  // Take one bit from the bit register, refilling from the buffered word.
  function automatic bit fetch_bit(output bit b);
    if ((bit_reg >> 1) == 0) begin
      if (!word_buf_full) return 1'b0;
      word_buf_full = 1'b0;
      check_acc ^= word_buf;
      b = word_buf[0];
      bit_reg = (word_buf >> 1) | bku_pkg::SENTINEL_BIT;
    end else begin
      b = bit_reg[0];
      bit_reg = bit_reg >> 1;
    end
    return 1'b1;
  endfunction

  // Predict the result of one beat and advance the predictor state.
  function automatic unpack_res_t predict_unpack(input logic op, input logic [31:0] w);
    unpack_res_t r;
    bit b, emit, stop;
    r = '0;
    if (op == 1'b0) begin
      if (hdr_phase == 2'd0) begin
        bytes_left = w;
        hdr_phase = 2'd1;
        r.status = bku_pkg::STAT_ACCEPTED;
      end else if (hdr_phase == 2'd1) begin
        check_acc = w;
        hdr_phase = 2'd2;
        r.status = bku_pkg::STAT_ACCEPTED;
      end else if (hdr_phase == 2'd2) begin
        bit_reg = w;
        check_acc ^= w;
        hdr_phase = 2'd3;
        goto_state(bytes_left == 0 ? bku_pkg::CS_DONE : bku_pkg::CS_OP1, 1);
        r.status = bku_pkg::STAT_ACCEPTED;
      end else if (cmd_st == bku_pkg::CS_DONE || word_buf_full) begin
        r.status = bku_pkg::STAT_REFUSED;
      end else begin
        word_buf = w;
        word_buf_full = 1'b1;
        r.status = bku_pkg::STAT_ACCEPTED;
      end
    end else if (hdr_phase != 2'd3) begin
      r.status = bku_pkg::STAT_NEEDWORD;
    end else if (cmd_st == bku_pkg::CS_DONE) begin
      r.status = bku_pkg::STAT_FINISHED;
    end else begin
      r.status = bku_pkg::STAT_NEEDWORD;
      stop = 1'b0;
      while (!stop) begin
        emit = 1'b0;
        while (code_left > 0 && fetch_bit(b)) begin
          code_acc = {code_acc[14:0], b};
          code_left--;
        end
        if (code_left > 0) begin
          stop = 1'b1;
        end else begin
          case (cmd_st)
            bku_pkg::CS_OP1: begin
              if (code_acc == 0) goto_state(bku_pkg::CS_OP2, 1);
              else goto_state(bku_pkg::CS_OP3, 2);
            end
            bku_pkg::CS_OP2: begin
              if (code_acc == 0) goto_state(bku_pkg::CS_LITLEN3, 3);
              else begin
                run_len = 9'd2;
                goto_state(bku_pkg::CS_OFF, 8);
              end
            end
            bku_pkg::CS_OP3: begin
              case (code_acc[1:0])
                2'd0: begin run_len = 9'd3; goto_state(bku_pkg::CS_OFF, 9); end
                2'd1: begin run_len = 9'd4; goto_state(bku_pkg::CS_OFF, 10); end
                2'd2: goto_state(bku_pkg::CS_CPYLEN, 8);
                default: goto_state(bku_pkg::CS_LITLEN8, 8);
              endcase
            end
            bku_pkg::CS_LITLEN3: begin
              run_len = 9'(code_acc[2:0]) + 9'd1;
              goto_state(bku_pkg::CS_LITBYTE, 8);
            end
            bku_pkg::CS_LITLEN8: begin
              run_len = 9'(code_acc[7:0]) + 9'd9;
              goto_state(bku_pkg::CS_LITBYTE, 8);
            end
            bku_pkg::CS_CPYLEN: begin
              run_len = 9'(code_acc[7:0]) + 9'd1;
              goto_state(bku_pkg::CS_OFF, 12);
            end
            bku_pkg::CS_OFF: begin
              copy_off = code_acc[11:0];
              goto_state(bku_pkg::CS_COPY, 0);
            end
            bku_pkg::CS_LITBYTE: begin
              r.data = code_acc[7:0];
              emit = 1'b1;
            end
            bku_pkg::CS_COPY: begin
              r.data = hist_mem[hist_ptr - copy_off];
              emit = 1'b1;
            end
            default: goto_state(bku_pkg::CS_OP1, 1);
          endcase
          if (emit) begin
            hist_mem[hist_ptr] = r.data;
            hist_ptr = hist_ptr + 12'd1;
            run_len = run_len - 9'd1;
            bytes_left = bytes_left - 32'd1;
            r.status = bku_pkg::STAT_BYTE;
            if (bytes_left == 0) begin
              r.last = 1'b1;
              r.ok   = (check_acc == 0);
              r.over = (run_len != 0);
              goto_state(bku_pkg::CS_DONE, 0);
            end else if (run_len == 0) begin
              goto_state(bku_pkg::CS_OP1, 1);
            end else if (cmd_st == bku_pkg::CS_LITBYTE) begin
              goto_state(bku_pkg::CS_LITBYTE, 8);
            end
            stop = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Append a field to the bit stream, most significant bit first.
  task automatic put_field(input int value, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) stream_bits.push_back(value[i]);
  endtask

  task automatic encode_literal(input int n);
    int v;
    if (n <= 8) begin
      put_field(0, 2);
      put_field(n - 1, 3);
    end else begin
      put_field(7, 3);
      put_field(n - 9, 8);
    end
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: v = 8'h00;
        1: v = 8'hFF;
        default: v = $urandom_range(0, 255);
      endcase
      put_field(v, 8);
    end
    bytes_encoded += n;
  endtask

  // Copy of n bytes; n of 2, 3 or 4 uses the short forms. Offset stays in written history.
  task automatic encode_copy(input int n, input bit max_off);
    int obits, omax, off;
    case (n)
      2: begin put_field(1, 2); obits = 8; end
      3: begin put_field(4, 3); obits = 9; end
      4: begin put_field(5, 3); obits = 10; end
      default: begin
        put_field(6, 3);
        put_field(n - 1, 8);
        obits = 12;
      end
    endcase
    omax = (1 << obits) - 1;
    if (omax > bytes_encoded) omax = bytes_encoded;
    off = max_off ? omax : $urandom_range(1, omax);
    put_field(off, obits);
    bytes_encoded += n;
  endtask

  task automatic add_beat(input logic op, input logic [31:0] w);
    beat_t bt;
    bt.op   = op;
    bt.word = w;
    bt.res  = predict_unpack(op, w);
    pending_beats.push_back(bt);
  endtask

  // Build one well-formed stream and the beat sequence that feeds it.
  task automatic build_stimulus();
    logic [31:0] first_word, w, check_word;
    int k, idx, decl_size;
    unpack_res_t r;
    bytes_encoded = 0;
    encode_literal(8);
    encode_copy(2, 1'b0);
    encode_copy(3, 1'b1);
    encode_copy(4, 1'b1);
    encode_copy(1, 1'b0);
    encode_literal(9);
    encode_literal(1);
    encode_copy(256, 1'b1);
    encode_literal(264);
    encode_copy(2, 1'b1);
    while (bytes_encoded < BYTE_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: encode_literal($urandom_range(1, 8));
        3: encode_literal($urandom_range(9, 30));
        4: encode_copy(2, 1'b0);
        5: encode_copy(3, 1'b0);
        6: encode_copy(4, 1'b0);
        7: encode_copy($urandom_range(0, 7) == 0 ? 256 : $urandom_range(1, 12),
                       $urandom_range(0, 3) == 0);
        default: encode_literal($urandom_range(1, 3));
      endcase
    end
    // The first bit word holds k bits under its top set bit; refills hold 32.
    k = $urandom_range(0, 31);
    first_word = 32'd1 << k;
    for (int i = 0; i < k; i++)
      first_word[i] = stream_bits.size() > 0 ? stream_bits.pop_front() : 1'($urandom);
    check_word = first_word;
    while (stream_bits.size() > 0) begin
      for (int i = 0; i < 32; i++)
        w[i] = stream_bits.size() > 0 ? stream_bits.pop_front() : 1'($urandom);
      refill_words.push_back(w);
      check_word ^= w;
    end
    if ($urandom_range(0, 3) == 0) check_word = $urandom;
    decl_size = bytes_encoded - ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));

    add_beat(1'b1, $urandom);
    add_beat(1'b0, decl_size);
    add_beat(1'b0, check_word);
    add_beat(1'b0, first_word);
    idx = 0;
    while (cmd_st != bku_pkg::CS_DONE) begin
      add_beat(1'b1, $urandom);
      r = pending_beats[$].res;
      if (r.status == bku_pkg::STAT_NEEDWORD) begin
        if (idx == refill_words.size()) break;
        add_beat(1'b0, refill_words[idx]);
        idx++;
        // A word offered while the buffer is full is refused and ignored.
        if ($urandom_range(0, 7) == 0) add_beat(1'b0, $urandom);
      end
    end
    add_beat(1'b1, $urandom);
    add_beat(1'b0, $urandom);
  endtask

  // Sender: pops beats, idles at random, and pauses once until all results are in.
  always @(posedge clk_i) begin
    beat_t bt;
    bit nv;
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (in_valid_i) begin
        bt = pending_beats.pop_front();
        expected_results.push_back(bt.res);
        beats_sent++;
      end
      if (beats_sent == 400 && !pause_done) sender_paused = 1'b1;
      if (sender_paused && expected_results.size() == 0 && !out_valid_o) begin
        sender_paused = 1'b0;
        pause_done = 1'b1;
      end
      nv = 1'b0;
      if (pending_beats.size() > 0 && !sender_paused &&
          ((beats_sent >= 100 && beats_sent < 250) || $urandom_range(0, 99) >= 23)) begin
        bt = pending_beats[0];
        opcode_i      <= bt.op;
        packed_word_i <= bt.word;
        nv = 1'b1;
      end
      in_valid_i <= nv;
    end
  end

  // Receiver: compares each result beat with the oldest expectation.
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    unpack_res_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d byte %02h", $time, status_o, data_byte_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status_o == bku_pkg::STAT_BYTE) bytes_seen++;
          if ({status_o, data_byte_o, last_o, check_ok_o, overrun_o} != exp_r) begin
            $display("%0t: mismatch expected status %0d byte %02h last %0b ok %0b over %0b",
                     $time, exp_r.status, exp_r.data, exp_r.last, exp_r.ok, exp_r.over);
            $display("%0t:          actual status %0d byte %02h last %0b ok %0b over %0b",
                     $time, status_o, data_byte_o, last_o, check_ok_o, overrun_o);
            errors++;
          end
        end
      end
      // One long hold-off so that the block backs up into its input.
      if (results_seen == 200 && !hold_done) hold_cycles = 400;
      if (hold_cycles > 0) begin
        hold_cycles--;
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (results_seen >= 500 && results_seen < 650) ||
                       ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time, expected_results.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Reset, build the stream, wait for completion and report.
  initial begin
    hdr_phase = '0; bit_reg = '0; check_acc = '0; bytes_left = '0; word_buf = '0;
    word_buf_full = 1'b0; cmd_st = bku_pkg::CS_OP1; code_acc = '0; code_left = 0;
    run_len = '0; copy_off = '0; hist_ptr = '0;
    build_stimulus();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_beats.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d beats, %0d results and %0d decoded bytes of one stream,",
             beats_sent, results_seen, bytes_seen);
    $display("with all six commands, buffer refusals, refill starvation and stalls.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
